// File: hdl/drive_request_framer_crc16_assert.svh
// Assertion macros used by the framer RTL.
`ifndef DRIVE_REQUEST_FRAMER_CRC16_ASSERT_SVH
`define DRIVE_REQUEST_FRAMER_CRC16_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRFC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DRFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

// File: hdl/drfc_pkg.sv
`default_nettype none

package drfc_pkg;

    localparam int PC_W      = 6;
    localparam int ROM_DEPTH = 42;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Byte sources selected by a control word.
    localparam logic [3:0] SRC_IMM    = 4'd0;
    localparam logic [3:0] SRC_CODE2  = 4'd1;
    localparam logic [3:0] SRC_CODE1  = 4'd2;
    localparam logic [3:0] SRC_CODE0  = 4'd3;
    localparam logic [3:0] SRC_SUB    = 4'd4;
    localparam logic [3:0] SRC_VAL2   = 4'd5;
    localparam logic [3:0] SRC_VAL1   = 4'd6;
    localparam logic [3:0] SRC_VAL0   = 4'd7;
    localparam logic [3:0] SRC_CRC_HI = 4'd8;
    localparam logic [3:0] SRC_CRC_LO = 4'd9;

    // Jump conditions, evaluated while the step's byte is emitted.
    localparam logic [2:0] JC_NONE     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_DT0      = 3'd2;
    localparam logic [2:0] JC_DT1      = 3'd3;
    localparam logic [2:0] JC_CODE_HI  = 3'd4;
    localparam logic [2:0] JC_CODE_MID = 3'd5;

    // Program entry points and jump targets.
    localparam logic [PC_W-1:0] A_WRITE  = 6'd0;
    localparam logic [PC_W-1:0] A_DT0    = 6'd18;
    localparam logic [PC_W-1:0] A_WR_INT = 6'd12;
    localparam logic [PC_W-1:0] A_READ   = 6'd25;
    localparam logic [PC_W-1:0] A_RD_MID = 6'd30;
    localparam logic [PC_W-1:0] A_RD_HI  = 6'd34;
    localparam logic [PC_W-1:0] A_CRC    = 6'd40;

    localparam logic [7:0] B_WR_HDR = 8'hC5;
    localparam logic [7:0] B_RD_HDR = 8'hA5;
    localparam logic [7:0] B_RD_CMD = 8'h03;
    localparam logic [7:0] B_LEN_S  = 8'h05;
    localparam logic [7:0] B_LEN_L  = 8'h08;
    localparam logic [7:0] B_ZERO   = 8'h00;

    typedef struct packed {
        logic [3:0]      src;
        logic [7:0]      imm;
        logic [2:0]      jc;
        logic [PC_W-1:0] target;
        logic            last;
    } t_uop;

    typedef struct packed {
        logic       clear;
        logic       update;
        logic [7:0] data;
    } t_crc_ctl;

    function automatic t_uop f_uop(logic [3:0] src, logic [7:0] imm, logic [2:0] jc,
                                   logic [PC_W-1:0] target, logic last);
        t_uop u;
        u.src    = src;
        u.imm    = imm;
        u.jc     = jc;
        u.target = target;
        u.last   = last;
        return u;
    endfunction

    function automatic t_uop f_emit(logic [3:0] src);
        return f_uop(src, B_ZERO, JC_NONE, A_WRITE, 1'b0);
    endfunction

    function automatic t_uop f_const(logic [7:0] imm);
        return f_uop(SRC_IMM, imm, JC_NONE, A_WRITE, 1'b0);
    endfunction

    // Microcode program: write frames from address zero, read frames from A_READ.
    function automatic t_uop f_rom(logic [PC_W-1:0] pc);
        t_uop u;
        case (pc)
            6'd0:  u = f_const(B_WR_HDR);
            6'd1:  u = f_uop(SRC_IMM, B_ZERO, JC_DT0, A_DT0, 1'b0);
            6'd2:  u = f_const(B_LEN_L);
            6'd3:  u = f_emit(SRC_CODE1);
            6'd4:  u = f_emit(SRC_CODE0);
            6'd5:  u = f_uop(SRC_SUB, B_ZERO, JC_DT1, A_WR_INT, 1'b0);
            6'd6:  u = f_emit(SRC_VAL2);
            6'd7:  u = f_emit(SRC_VAL1);
            6'd8:  u = f_emit(SRC_VAL0);
            6'd9:  u = f_const(B_ZERO);
            6'd10: u = f_const(B_ZERO);
            6'd11: u = f_uop(SRC_IMM, B_ZERO, JC_ALWAYS, A_CRC, 1'b0);
            6'd12: u = f_const(B_ZERO);
            6'd13: u = f_const(B_ZERO);
            6'd14: u = f_const(B_ZERO);
            6'd15: u = f_emit(SRC_VAL2);
            6'd16: u = f_emit(SRC_VAL1);
            6'd17: u = f_uop(SRC_VAL0, B_ZERO, JC_ALWAYS, A_CRC, 1'b0);
            6'd18: u = f_const(B_LEN_S);
            6'd19: u = f_emit(SRC_CODE1);
            6'd20: u = f_emit(SRC_CODE0);
            6'd21: u = f_emit(SRC_SUB);
            6'd22: u = f_const(B_ZERO);
            6'd23: u = f_emit(SRC_VAL1);
            6'd24: u = f_uop(SRC_VAL0, B_ZERO, JC_ALWAYS, A_CRC, 1'b0);
            6'd25: u = f_uop(SRC_IMM, B_RD_HDR, JC_CODE_HI, A_RD_HI, 1'b0);
            6'd26: u = f_uop(SRC_IMM, B_RD_CMD, JC_CODE_MID, A_RD_MID, 1'b0);
            6'd27: u = f_const(8'h01);
            6'd28: u = f_emit(SRC_CODE0);
            6'd29: u = f_uop(SRC_SUB, B_ZERO, JC_ALWAYS, A_CRC, 1'b0);
            6'd30: u = f_const(8'h02);
            6'd31: u = f_emit(SRC_CODE1);
            6'd32: u = f_emit(SRC_CODE0);
            6'd33: u = f_uop(SRC_SUB, B_ZERO, JC_ALWAYS, A_CRC, 1'b0);
            6'd34: u = f_const(B_RD_CMD);
            6'd35: u = f_const(8'h03);
            6'd36: u = f_emit(SRC_CODE2);
            6'd37: u = f_emit(SRC_CODE1);
            6'd38: u = f_emit(SRC_CODE0);
            6'd39: u = f_emit(SRC_SUB);
            6'd40: u = f_emit(SRC_CRC_HI);
            6'd41: u = f_uop(SRC_CRC_LO, B_ZERO, JC_NONE, A_WRITE, 1'b1);
            default: u = f_uop(SRC_CRC_LO, B_ZERO, JC_NONE, A_WRITE, 1'b1);
        endcase
        return u;
    endfunction

    // Remainder of idx<<8 for the check polynomial, MSB first.
    function automatic logic [15:0] f_crc_table(logic [7:0] idx);
        logic [15:0] r;
        r = {idx, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/drfc_crc16.sv
`default_nettype none

module drfc_crc16
    import drfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_crc_ctl    i_ctl,
    output logic [15:0]      o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // Table-driven update, one frame byte per cycle while update is set.
    always_comb begin
        n_crc = r_crc;
        if (i_ctl.clear) begin
            n_crc = 16'h0000;
        end else if (i_ctl.update) begin
            n_crc = f_crc_table(r_crc[15:8]) ^ {r_crc[7:0], 8'h00} ^ {8'h00, i_ctl.data};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= 16'h0000;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

// File: hdl/drive_request_framer_crc16.sv
// Drive parameter request framer.
// The input channel (i_valid / o_stall) takes one request: operation, code,
// value, subindex and data type. The output channel (o_valid / i_stall)
// returns the serial frame one byte per transaction, with o_last_byte set on
// the second check byte. Frames are 11 or 14 bytes for a write and 7, 8 or 9
// bytes for a read.
// A microcode table emits one byte per step while the output register is
// free. The request is registered first; the first byte is then selected
// from the table and enters the output register.
// The next request is accepted in the cycle that the last byte of the current
// frame enters the output register, so back-to-back requests keep the line
// busy with no gap between frames.
// When the receiver stalls, the held byte stays and the sequencer waits.
// Synchronous reset empties the output register and idles the sequencer;
// the block keeps nothing between requests.
`default_nettype none

module drive_request_framer_crc16
    import drfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_operation,
    input  wire logic [23:0] i_code_number,
    input  wire logic [23:0] i_param_value,
    input  wire logic [7:0]  i_sub_index,
    input  wire logic [1:0]  i_data_type,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_frame_byte,
    output logic             o_last_byte
);

    `include "drive_request_framer_crc16_assert.svh"

    logic            r_busy;
    logic [PC_W-1:0] r_pc;
    logic [23:0]     r_code;
    logic [23:0]     r_val;
    logic [7:0]      r_sub;
    logic [1:0]      r_dt;
    logic            r_valid;
    logic [7:0]      r_byte;
    logic            r_last;

    t_uop            uop;
    t_crc_ctl        crc_ctl;
    logic [15:0]     crc;
    logic            slot_free;
    logic            fire;
    logic            in_acc;
    logic            take;
    logic [7:0]      byte_sel;

    assign uop       = f_rom(r_pc);
    assign slot_free = !r_valid || !i_stall;
    assign fire      = r_busy && slot_free;
    assign o_stall   = r_busy && !(fire && uop.last);
    assign in_acc    = i_valid && !o_stall;

    always_comb begin
        unique case (uop.src)
            SRC_IMM:    byte_sel = uop.imm;
            SRC_CODE2:  byte_sel = r_code[23:16];
            SRC_CODE1:  byte_sel = r_code[15:8];
            SRC_CODE0:  byte_sel = r_code[7:0];
            SRC_SUB:    byte_sel = r_sub;
            SRC_VAL2:   byte_sel = r_val[23:16];
            SRC_VAL1:   byte_sel = r_val[15:8];
            SRC_VAL0:   byte_sel = r_val[7:0];
            SRC_CRC_HI: byte_sel = crc[15:8];
            SRC_CRC_LO: byte_sel = crc[7:0];
            default:    byte_sel = B_ZERO;
        endcase
    end

    always_comb begin
        unique case (uop.jc)
            JC_NONE:     take = 1'b0;
            JC_ALWAYS:   take = 1'b1;
            JC_DT0:      take = (r_dt == 2'd0);
            JC_DT1:      take = (r_dt == 2'd1);
            JC_CODE_HI:  take = (r_code[23:16] != 8'h00);
            JC_CODE_MID: take = (r_code[15:8] != 8'h00);
            default:     take = 1'b0;
        endcase
    end

    // The check bytes themselves are not folded into the check.
    always_comb begin
        crc_ctl.clear  = in_acc;
        crc_ctl.update = fire && (uop.src != SRC_CRC_HI) && (uop.src != SRC_CRC_LO);
        crc_ctl.data   = byte_sel;
    end

    drfc_crc16 u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (crc_ctl),
        .o_crc   (crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= A_WRITE;
            r_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_pc   <= i_operation ? A_READ : A_WRITE;
            end else if (fire) begin
                if (uop.last) begin
                    r_busy <= 1'b0;
                end
                r_pc <= take ? uop.target : r_pc + 1'b1;
            end
            if (fire) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_code_number;
            r_val  <= i_param_value;
            r_sub  <= i_sub_index;
            r_dt   <= i_data_type;
        end
        if (fire) begin
            r_byte <= byte_sel;
            r_last <= uop.last;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_last_byte  = r_last;

    `DRFC_ASSERT_IMPL(a_acc_idle, i_clk, i_rst_n, in_acc, !r_busy || (fire && uop.last))
    `DRFC_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, fire && uop.last && !in_acc, !r_busy)
    `DRFC_ASSERT_IMPL(a_pc_range, i_clk, i_rst_n, r_busy, r_pc < PC_W'(ROM_DEPTH))
    `DRFC_ASSERT_IMPL(a_last_crc, i_clk, i_rst_n, fire && uop.last, uop.src == SRC_CRC_LO)

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;
    localparam logic [1:0] DT_INT24  = 2'd0;
    localparam logic [1:0] DT_INT48  = 2'd1;
    localparam logic [1:0] DT_REAL48 = 2'd2;
    localparam logic [1:0] DT_SPARE  = 2'd3;

    localparam logic [7:0]  SOF_WRITE  = 8'hC5;
    localparam logic [7:0]  SOF_READ   = 8'hA5;
    localparam logic [7:0]  CMD_READ   = 8'h03;
    localparam logic [7:0]  LEN_SHORT  = 8'h05;
    localparam logic [7:0]  LEN_LONG   = 8'h08;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;
    localparam logic [15:0] CCITT_POLY = 16'h1021;

    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 26;
    localparam int SETTLE_CYCLES    = 20;
    localparam int MAX_REPORTS      = 40;
    localparam int NUM_DIRECTED     = 17;

    typedef struct packed {
        logic        op;
        logic [23:0] code;
        logic [23:0] value;
        logic [7:0]  sub;
        logic [1:0]  dtype;
        logic [3:0]  frame_len;  // zero where the length is left to the predictor
    } t_request;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_frame_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_operation;
    logic [23:0] i_code_number;
    logic [23:0] i_param_value;
    logic [7:0]  i_sub_index;
    logic [1:0]  i_data_type;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;

    t_frame_byte expected_bytes[$];
    logic [3:0]  typed_lengths[$];
    t_request    directed_rows[NUM_DIRECTED];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int mismatch_count = 0;
    int bytes_seen    = 0;
    int bytes_in_frame = 0;
    int quiet_cycles  = 0;
    int write_frames[4] = '{0, 0, 0, 0};
    int read_frames[3]  = '{0, 0, 0};

    drive_request_framer_crc16 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_code_number (i_code_number),
        .i_param_value (i_param_value),
        .i_sub_index   (i_sub_index),
        .i_data_type   (i_data_type),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_frame_byte  (o_frame_byte),
        .o_last_byte   (o_last_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Table-driven check update: the table entry is the remainder of the
    // high check byte shifted up by eight, reduced bit by bit.
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] chk, input logic [7:0] b);
        logic [15:0] rem;
        rem = {chk[15:8], 8'h00};
        repeat (8) begin
            rem = rem[15] ? ((rem << 1) ^ CCITT_POLY) : (rem << 1);
        end
        return rem ^ {chk[7:0], 8'h00} ^ {8'h00, b};
    endfunction

    function automatic void queue_expected_frame(input t_request r);
        logic [7:0]  frame_q[$];
        logic [15:0] chk;
        t_frame_byte fb;
        chk = 16'h0000;
        if (r.op == OP_WRITE) begin
            frame_q.push_back(SOF_WRITE);
            frame_q.push_back(PAD_BYTE);
            frame_q.push_back((r.dtype == DT_INT24) ? LEN_SHORT : LEN_LONG);
            frame_q.push_back(r.code[15:8]);
            frame_q.push_back(r.code[7:0]);
            frame_q.push_back(r.sub);
            case (r.dtype)
                DT_INT24: begin
                    frame_q.push_back(PAD_BYTE);
                    frame_q.push_back(r.value[15:8]);
                    frame_q.push_back(r.value[7:0]);
                end
                DT_INT48: begin
                    repeat (3) frame_q.push_back(PAD_BYTE);
                    frame_q.push_back(r.value[23:16]);
                    frame_q.push_back(r.value[15:8]);
                    frame_q.push_back(r.value[7:0]);
                end
                default: begin
                    // The spare type is laid out like the real type.
                    frame_q.push_back(r.value[23:16]);
                    frame_q.push_back(r.value[15:8]);
                    frame_q.push_back(r.value[7:0]);
                    repeat (3) frame_q.push_back(PAD_BYTE);
                end
            endcase
        end else begin
            frame_q.push_back(SOF_READ);
            frame_q.push_back(CMD_READ);
            if (r.code > 24'h00FFFF) begin
                frame_q.push_back(8'd3);
                frame_q.push_back(r.code[23:16]);
                frame_q.push_back(r.code[15:8]);
            end else if (r.code > 24'h0000FF) begin
                frame_q.push_back(8'd2);
                frame_q.push_back(r.code[15:8]);
            end else begin
                frame_q.push_back(8'd1);
            end
            frame_q.push_back(r.code[7:0]);
            frame_q.push_back(r.sub);
        end
        foreach (frame_q[k]) begin
            chk = crc_ccitt_step(chk, frame_q[k]);
        end
        frame_q.push_back(chk[15:8]);
        frame_q.push_back(chk[7:0]);
        foreach (frame_q[k]) begin
            fb.data    = frame_q[k];
            fb.is_last = (k == frame_q.size() - 1);
            expected_bytes.push_back(fb);
        end
    endfunction

    function automatic t_request random_request();
        t_request r;
        r.op = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       r.code = 24'($urandom_range(255));
            1:       r.code = 24'($urandom_range(65535, 256));
            2:       r.code = 24'($urandom_range(24'hFFFFFF, 65536));
            default: r.code = 24'($urandom);
        endcase
        r.value     = 24'($urandom);
        r.sub       = 8'($urandom);
        r.dtype     = 2'($urandom_range(3));
        r.frame_len = 4'd0;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transaction, with valid still high.
    task automatic send_request(input t_request r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_operation   = r.op;
        i_code_number = r.code;
        i_param_value = r.value;
        i_sub_index   = r.sub;
        i_data_type   = r.dtype;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        queue_expected_frame(r);
        typed_lengths.push_back(r.frame_len);
        if (r.op == OP_WRITE) begin
            write_frames[r.dtype]++;
        end else if (r.code > 24'h00FFFF) begin
            read_frames[2]++;
        end else if (r.code > 24'h0000FF) begin
            read_frames[1]++;
        end else begin
            read_frames[0]++;
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        t_frame_byte want;
        logic [3:0]  typed_len;
        if (i_rst_n && o_valid && !i_stall) begin
            bytes_seen++;
            bytes_in_frame++;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %02h with no frame pending", o_frame_byte));
            end else begin
                want = expected_bytes.pop_front();
                if (o_frame_byte !== want.data) begin
                    report_mismatch($sformatf("frame byte %02h, expected %02h",
                                              o_frame_byte, want.data));
                end
                if (o_last_byte !== want.is_last) begin
                    report_mismatch($sformatf("last flag %b, expected %b",
                                              o_last_byte, want.is_last));
                end
            end
            if (o_last_byte) begin
                if (typed_lengths.size() != 0) begin
                    typed_len = typed_lengths.pop_front();
                    if (typed_len != 0 && bytes_in_frame != typed_len) begin
                        report_mismatch($sformatf("frame of %0d bytes, table gives %0d",
                                                  bytes_in_frame, typed_len));
                    end
                end
                bytes_in_frame = 0;
            end
        end
    end

    // Ends the run when neither channel completes a transaction for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_operation   = OP_WRITE;
        i_code_number = 24'd0;
        i_param_value = 24'd0;
        i_sub_index   = 8'd0;
        i_data_type   = DT_INT24;

        directed_rows = '{
            '{OP_WRITE, 24'h000000, 24'h000000, 8'h00, DT_INT24,  4'd11},
            '{OP_WRITE, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, DT_INT24,  4'd11},
            '{OP_WRITE, 24'h00BEEF, 24'hABCDEF, 8'h5A, DT_INT24,  4'd11},
            '{OP_WRITE, 24'h000000, 24'h000000, 8'h00, DT_INT48,  4'd14},
            '{OP_WRITE, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, DT_INT48,  4'd14},
            '{OP_WRITE, 24'h001234, 24'h123456, 8'h01, DT_INT48,  4'd14},
            '{OP_WRITE, 24'h000000, 24'h000000, 8'h00, DT_REAL48, 4'd14},
            '{OP_WRITE, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, DT_REAL48, 4'd14},
            '{OP_WRITE, 24'h00ABCD, 24'h7F8001, 8'h80, DT_SPARE,  4'd14},
            '{OP_WRITE, 24'h123456, 24'h000000, 8'hC3, DT_REAL48, 4'd14},
            '{OP_READ,  24'h000000, 24'h000000, 8'h00, DT_INT24,  4'd7},
            '{OP_READ,  24'h0000FF, 24'hFFFFFF, 8'hFF, DT_SPARE,  4'd7},
            '{OP_READ,  24'h000100, 24'h000000, 8'h00, DT_INT48,  4'd8},
            '{OP_READ,  24'h00FFFF, 24'h000000, 8'hFF, DT_INT24,  4'd8},
            '{OP_READ,  24'h010000, 24'h000000, 8'h00, DT_INT24,  4'd9},
            '{OP_READ,  24'hFFFFFF, 24'hFFFFFF, 8'hFF, DT_REAL48, 4'd9},
            '{OP_READ,  24'h0A0B0C, 24'h123456, 8'h77, DT_INT48,  4'd9}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 46; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_idle_pct = 31; rx_stall_pct = 31; end
            endcase
            if (phase == 0) begin
                foreach (directed_rows[k]) begin
                    send_request(directed_rows[k]);
                end
            end
            repeat (RANDOM_PER_PHASE) send_request(random_request());
        end
        i_valid = 1'b0;

        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Framed %0d writes (24-bit %0d, 48-bit %0d, real48 %0d, spare type %0d)",
                 write_frames[0] + write_frames[1] + write_frames[2] + write_frames[3],
                 write_frames[0], write_frames[1], write_frames[2], write_frames[3]);
        $display("and %0d reads (1/2/3 code bytes: %0d/%0d/%0d); %0d bytes compared.",
                 read_frames[0] + read_frames[1] + read_frames[2],
                 read_frames[0], read_frames[1], read_frames[2], bytes_seen);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
